FILE: rtl/tps_pkg.sv
// Shared types and constants for the touch position scaler.
// Used by the interfaces, controller, datapath, divider and top level; depends on nothing.
package tps_pkg;

    // Configuration port index width and register indexes.
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_X_OFFSET = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_Y_OFFSET = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_X_SPAN   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_Y_SPAN   = 3'd3;

    // Result and arithmetic constants.
    localparam int QuoBits   = 8;
    localparam int ZShift    = 2;
    localparam int SpanReset = 4096;
    localparam logic [QuoBits-1:0] FullScale = 8'hFF;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_PREP_X  = 7'b0000010,
        ST_START_X = 7'b0000100,
        ST_WAIT_X  = 7'b0001000,
        ST_START_Y = 7'b0010000,
        ST_WAIT_Y  = 7'b0100000,
        ST_PUSH    = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic prep;
        logic sel_y;
        logic div_start;
        logic store_x;
        logic store_y;
        logic load_out;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pz_zero;
        logic div_done;
    } t_ctl_sts;

endpackage

FILE: rtl/tps_ifs.sv
// Handshake interfaces for the sample, result and configuration channels.
// Depends on tps_pkg for the configuration index width.
interface tps_in_if #(
    parameter int RAW_BITS = 13
);
    logic                valid;
    logic                ready;
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;
    logic [7:0]          pressure;

    modport source (output valid, output raw_x, output raw_y, output pressure, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input pressure, output ready);
endinterface

interface tps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] scaled_x;
    logic [7:0] scaled_y;
    logic [7:0] scaled_z;

    modport source (output valid, output scaled_x, output scaled_y, output scaled_z,
                    input ready);
    modport sink   (input valid, input scaled_x, input scaled_y, input scaled_z,
                    output ready);
endinterface

interface tps_cfg_if #(
    parameter int RAW_BITS = 13
);
    logic                         valid;
    logic                         ready;
    logic [tps_pkg::CfgIdxW-1:0]  index;
    logic [RAW_BITS-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tps_div.sv
// Iterative restoring divider giving an 8-bit quotient saturated at full scale.
// Depends on tps_pkg for the quotient width and full-scale constant.
module tps_div #(
    parameter int RAW_BITS = 13
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [RAW_BITS+tps_pkg::QuoBits-1:0] i_num,
    input  logic [RAW_BITS-1:0]                i_den,
    output logic                               o_done,
    output logic [tps_pkg::QuoBits-1:0]        o_quo
);
    localparam int QB   = tps_pkg::QuoBits;
    localparam int CntW = $clog2(QB);

    logic                r_busy;
    logic                r_sat;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [RAW_BITS-1:0] r_rem;
    logic [QB-1:0]       r_low;
    logic [QB-1:0]       r_quo;

    logic [RAW_BITS:0]   rem_sh;
    logic [RAW_BITS:0]   rem_sub;
    logic                rem_ge;
    logic                sat_now;

    // One quotient bit per cycle: shift in the next numerator bit and try the subtract.
    always_comb begin
        rem_sh  = {r_rem, r_low[QB-1]};
        rem_ge  = rem_sh >= {1'b0, i_den};
        rem_sub = rem_sh - {1'b0, i_den};
        // A quotient above full scale, including a zero divisor, saturates.
        sat_now = i_num >= {i_den, {QB{1'b0}}};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_sat || r_cnt == CntW'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Remainder, pending numerator bits and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= sat_now;
            // Below saturation the upper numerator bits are already smaller than the divisor.
            r_rem <= i_num[RAW_BITS+QB-1:QB];
            r_low <= i_num[QB-1:0];
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_sat) begin
                r_quo <= tps_pkg::FullScale;
            end else begin
                r_rem <= rem_ge ? rem_sub[RAW_BITS-1:0] : rem_sh[RAW_BITS-1:0];
                r_low <= {r_low[QB-2:0], 1'b0};
                r_quo <= {r_quo[QB-2:0], rem_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/tps_dp.sv
// Datapath: configuration registers, sample capture, offset and scale, held values and
// the output register. Depends on tps_pkg and instantiates tps_div.
module tps_dp #(
    parameter int RAW_BITS = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tps_pkg::t_ctl_cmd            i_cmd,
    output tps_pkg::t_ctl_sts            o_sts,
    input  logic                         i_cfg_we,
    input  logic [tps_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [RAW_BITS-1:0]          i_cfg_data,
    input  logic [RAW_BITS-1:0]          i_raw_x,
    input  logic [RAW_BITS-1:0]          i_raw_y,
    input  logic [7:0]                   i_pressure,
    output logic [7:0]                   o_scaled_x,
    output logic [7:0]                   o_scaled_y,
    output logic [7:0]                   o_scaled_z
);
    localparam int NumW = RAW_BITS + tps_pkg::QuoBits;
    localparam logic [RAW_BITS-1:0] SpanRst = RAW_BITS'(tps_pkg::SpanReset);

    logic [RAW_BITS-1:0] r_x_offset;
    logic [RAW_BITS-1:0] r_y_offset;
    logic [RAW_BITS-1:0] r_x_span;
    logic [RAW_BITS-1:0] r_y_span;
    logic [RAW_BITS-1:0] r_raw_x;
    logic [RAW_BITS-1:0] r_raw_y;
    logic [7:0]          r_pz;
    logic [7:0]          r_held_x;
    logic [7:0]          r_held_y;
    logic [NumW-1:0]     r_num;
    logic                r_sel_y;
    logic [7:0]          r_out_x;
    logic [7:0]          r_out_y;
    logic [7:0]          r_out_z;

    logic [RAW_BITS-1:0] raw_sel;
    logic [RAW_BITS-1:0] off_sel;
    logic [RAW_BITS-1:0] diff;
    logic [NumW-1:0]     n_num;
    logic [RAW_BITS-1:0] den;
    logic                div_done;
    logic [7:0]          div_quo;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset <= '0;
            r_y_offset <= '0;
            r_x_span   <= SpanRst;
            r_y_span   <= SpanRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tps_pkg::REG_X_OFFSET: r_x_offset <= i_cfg_data;
                tps_pkg::REG_Y_OFFSET: r_y_offset <= i_cfg_data;
                tps_pkg::REG_X_SPAN:   r_x_span   <= i_cfg_data;
                tps_pkg::REG_Y_SPAN:   r_y_span   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Offset with a floor at zero, then multiply by 255 as a shift and subtract.
    always_comb begin
        raw_sel = i_cmd.sel_y ? r_raw_y : r_raw_x;
        off_sel = i_cmd.sel_y ? r_y_offset : r_x_offset;
        diff    = (raw_sel > off_sel) ? (raw_sel - off_sel) : '0;
        n_num   = {diff, {tps_pkg::QuoBits{1'b0}}} - {{tps_pkg::QuoBits{1'b0}}, diff};
        den     = r_sel_y ? r_y_span : r_x_span;
    end

    // Sample capture and the numerator for the axis being worked on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
            r_pz    <= i_pressure;
        end
        if (i_cmd.prep) begin
            r_num   <= n_num;
            r_sel_y <= i_cmd.sel_y;
        end
    end

    tps_div #(
        .RAW_BITS (RAW_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Held positions, given again while nothing touches the pad.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else begin
            if (i_cmd.store_x) begin
                r_held_x <= div_quo;
            end
            if (i_cmd.store_y) begin
                r_held_y <= div_quo;
            end
        end
    end

    // Output register, which frees the datapath for the next sample.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x <= r_held_x;
            r_out_y <= r_held_y;
            r_out_z <= 8'(r_pz << tps_pkg::ZShift);
        end
    end

    assign o_sts.pz_zero  = (r_pz == 8'd0);
    assign o_sts.div_done = div_done;
    assign o_scaled_x     = r_out_x;
    assign o_scaled_y     = r_out_y;
    assign o_scaled_z     = r_out_z;

endmodule

FILE: rtl/tps_ctrl.sv
// Controller state machine: sample handshake, sequencing of the two axis divisions and
// the output valid flag. Depends on tps_pkg.
module tps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tps_pkg::t_ctl_sts i_sts,
    output tps_pkg::t_ctl_cmd o_cmd
);
    tps_pkg::t_state r_state;
    tps_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            tps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = tps_pkg::ST_PREP_X;
                end
            end
            tps_pkg::ST_PREP_X: begin
                // Without contact the held values are given unchanged.
                o_cmd.prep = 1'b1;
                n_state    = i_sts.pz_zero ? tps_pkg::ST_PUSH : tps_pkg::ST_START_X;
            end
            tps_pkg::ST_START_X: begin
                o_cmd.div_start = 1'b1;
                n_state         = tps_pkg::ST_WAIT_X;
            end
            tps_pkg::ST_WAIT_X: begin
                if (i_sts.div_done) begin
                    o_cmd.store_x = 1'b1;
                    o_cmd.prep    = 1'b1;
                    o_cmd.sel_y   = 1'b1;
                    n_state       = tps_pkg::ST_START_Y;
                end
            end
            tps_pkg::ST_START_Y: begin
                o_cmd.div_start = 1'b1;
                n_state         = tps_pkg::ST_WAIT_Y;
            end
            tps_pkg::ST_WAIT_Y: begin
                if (i_sts.div_done) begin
                    o_cmd.store_y = 1'b1;
                    n_state       = tps_pkg::ST_PUSH;
                end
            end
            tps_pkg::ST_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tps_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a load, cleared when the result is transferred.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tps_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == tps_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/touch_position_scaler.sv
// Top level of the touch position scaler: joins controller and datapath to the channels.
// Depends on tps_pkg, the interfaces in tps_ifs, tps_ctrl and tps_dp.
//
//   Channel   Direction  Handshake      Payload
//   i_in      sink       valid/ready    raw_x, raw_y, pressure
//   o_out     source     valid/ready    scaled_x, scaled_y, scaled_z
//   i_cfg     sink       valid/ready    index, data (always ready)
//
// A touched sample, after its transfer in, goes through the states to prepare x, then per
// axis a start and a wait on the divider (eight steps and the done flag), then the load.
// A saturating axis, including a zero span, skips the divider steps and gives full scale.
// An untouched sample goes from preparing x straight to the load. The input is ready
// again in the cycle after the load, so no new sample is taken while one is worked on;
// a result waiting in the output register stalls the next load until transferred.
// Reset is synchronous and active low; no clearing pass is needed.
module touch_position_scaler #(
    parameter int RAW_BITS = 13
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tps_in_if.sink    i_in,
    tps_out_if.source o_out,
    tps_cfg_if.sink   i_cfg
);
    tps_pkg::t_ctl_cmd cmd;
    tps_pkg::t_ctl_sts sts;
    logic              cfg_we;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    tps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tps_dp #(
        .RAW_BITS (RAW_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_raw_x     (i_in.raw_x),
        .i_raw_y     (i_in.raw_y),
        .i_pressure  (i_in.pressure),
        .o_scaled_x  (o_out.scaled_x),
        .o_scaled_y  (o_out.scaled_y),
        .o_scaled_z  (o_out.scaled_z)
    );

endmodule
